[src/aiptm_pkg.sv]
package aiptm_pkg;

  // Table geometry.
  localparam int PEERS          = 8;
  localparam int SLOTS_PER_PEER = 4;
  localparam int NSLOTS         = PEERS * SLOTS_PER_PEER;
  localparam int IDX_W          = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
  localparam int PEER_W         = (PEERS > 1) ? $clog2(PEERS) : 1;
  localparam int SLOT_W         = (SLOTS_PER_PEER > 1) ? $clog2(SLOTS_PER_PEER) : 1;

  // Address and field widths.
  localparam int ADDR_BITS = 128;
  localparam int HALF_W    = 64;
  localparam int LEN_W     = 8;
  localparam int FPEER_W   = 3;
  localparam int MASK_W    = 8;

  // Leading-zero count is split into chunks.
  localparam int CHUNK_W    = 16;
  localparam int CHUNKS     = ADDR_BITS / CHUNK_W;
  localparam int CHUNK_LZ_W = $clog2(CHUNK_W);

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;
  localparam logic [CFG_IDX_W-1:0] REG_PEER_ENABLE = '0;

  // Operation codes.
  localparam logic MODE_ADD    = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef struct packed {
    logic              mode;
    logic [2:0]        peer_number;
    logic [HALF_W-1:0] addr_high;
    logic [HALF_W-1:0] addr_low;
    logic [LEN_W-1:0]  prefix_len;
  } in_item_t;

  typedef struct packed {
    logic               ok;
    logic [FPEER_W-1:0] found_peer;
    logic [LEN_W-1:0]   match_len;
    logic               exact_hit;
  } out_item_t;

  typedef struct packed {
    logic [HALF_W-1:0] addr_upper;
    logic [HALF_W-1:0] addr_lower;
    logic [LEN_W-1:0]  prefix;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  // Side information that travels with each slot read.
  typedef struct packed {
    logic              live;
    logic              qualify;
    logic              last;
    logic [PEER_W-1:0] peer;
  } tag_t;

  // Match result for one slot.
  typedef struct packed {
    logic              live;
    logic              qualify;
    logic              last;
    logic [PEER_W-1:0] peer;
    logic [LEN_W-1:0]  match_len;
    logic [LEN_W-1:0]  prefix;
  } match_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_FIN
  } state_t;

endpackage

[src/allowed_ip_prefix_match_table.sv]
// A lookup scans all NSLOTS slots and an add the SLOTS_PER_PEER slots of its peer, reading
// one slot per cycle from the slot memory through the registered read into the match
// pipeline. A new item is taken only once the result of the previous one has been loaded
// into the output register, so items do not overlap.
// Reset clears the state machine, the enable mask and all slot valid bits at once;
// no clearing pass runs and items are taken in the first cycle after reset.
module allowed_ip_prefix_match_table (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  aiptm_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output aiptm_pkg::out_item_t                out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [aiptm_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [aiptm_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [aiptm_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready
);

  logic [aiptm_pkg::MASK_W-1:0]            peer_enable_mask_r;
  logic [aiptm_pkg::CFG_IDX_W-1:0]         reg_idx;
  logic                                    ram_we;
  logic [aiptm_pkg::IDX_W-1:0]             ram_waddr;
  logic [aiptm_pkg::IDX_W-1:0]             ram_raddr;
  aiptm_pkg::slot_entry_t                  ram_wdata;
  logic [aiptm_pkg::ENTRY_W-1:0]           ram_rdata;
  aiptm_pkg::tag_t                         tag;
  aiptm_pkg::match_t                       match_res;
  logic [aiptm_pkg::ADDR_BITS-1:0]         key;

  // Register file access.
  assign reg_idx = paddr[aiptm_pkg::CFG_ADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = (reg_idx == aiptm_pkg::REG_PEER_ENABLE) ?
                   aiptm_pkg::CFG_DATA_W'(peer_enable_mask_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peer_enable_mask_r <= '0;
    end else if (psel && penable && pwrite && pready &&
                 (reg_idx == aiptm_pkg::REG_PEER_ENABLE)) begin
      peer_enable_mask_r <= pwdata[aiptm_pkg::MASK_W-1:0];
    end
  end

  aiptm_ctrl u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .peer_enable_mask (peer_enable_mask_r),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .ram_we           (ram_we),
    .ram_waddr        (ram_waddr),
    .ram_wdata        (ram_wdata),
    .ram_raddr        (ram_raddr),
    .tag              (tag),
    .key              (key),
    .match_res        (match_res)
  );

  aiptm_ram #(
    .DEPTH (aiptm_pkg::NSLOTS),
    .WIDTH (aiptm_pkg::ENTRY_W),
    .AW    (aiptm_pkg::IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  aiptm_cpl u_cpl (
    .clk    (clk),
    .rst_n  (rst_n),
    .entry  (aiptm_pkg::slot_entry_t'(ram_rdata)),
    .tag    (tag),
    .key    (key),
    .result (match_res)
  );

endmodule

[src/aiptm_ram.sv]
module aiptm_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 136,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[src/aiptm_cpl.sv]
module aiptm_cpl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  aiptm_pkg::slot_entry_t           entry,
  input  aiptm_pkg::tag_t                  tag,
  input  logic [aiptm_pkg::ADDR_BITS-1:0]  key,
  output aiptm_pkg::match_t                result
);

  logic [aiptm_pkg::ADDR_BITS-1:0]         diff_r;
  logic [aiptm_pkg::LEN_W-1:0]             prefix1_r;
  aiptm_pkg::tag_t                         tag1_r;

  logic [aiptm_pkg::CHUNKS-1:0]            nz_nxt;
  logic [aiptm_pkg::CHUNK_LZ_W-1:0]        lz_nxt [aiptm_pkg::CHUNKS];
  logic [aiptm_pkg::CHUNKS-1:0]            nz2_r;
  logic [aiptm_pkg::CHUNK_LZ_W-1:0]        lz2_r [aiptm_pkg::CHUNKS];
  logic [aiptm_pkg::LEN_W-1:0]             prefix2_r;
  aiptm_pkg::tag_t                         tag2_r;

  logic [aiptm_pkg::LEN_W-1:0]             m_nxt;
  aiptm_pkg::match_t                       result_r;

  // Stage one: difference between the stored address and the key.
  always_ff @(posedge clk) begin
    diff_r         <= {entry.addr_upper, entry.addr_lower} ^ key;
    prefix1_r      <= entry.prefix;
    tag1_r.qualify <= tag.qualify;
    tag1_r.last    <= tag.last;
    tag1_r.peer    <= tag.peer;
    if (!rst_n) begin
      tag1_r.live <= 1'b0;
    end else begin
      tag1_r.live <= tag.live;
    end
  end

  // Stage two: per-chunk zero flag and leading-zero count.
  always_comb begin
    logic [aiptm_pkg::CHUNK_W-1:0] chunk;
    for (int c = 0; c < aiptm_pkg::CHUNKS; c++) begin
      chunk = diff_r[aiptm_pkg::ADDR_BITS-1-c*aiptm_pkg::CHUNK_W -: aiptm_pkg::CHUNK_W];
      nz_nxt[c] = |chunk;
      lz_nxt[c] = '0;
      for (int b = 0; b < aiptm_pkg::CHUNK_W; b++) begin
        if (chunk[b]) begin
          lz_nxt[c] = aiptm_pkg::CHUNK_LZ_W'(aiptm_pkg::CHUNK_W - 1 - b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    nz2_r          <= nz_nxt;
    lz2_r          <= lz_nxt;
    prefix2_r      <= prefix1_r;
    tag2_r.qualify <= tag1_r.qualify;
    tag2_r.last    <= tag1_r.last;
    tag2_r.peer    <= tag1_r.peer;
    if (!rst_n) begin
      tag2_r.live <= 1'b0;
    end else begin
      tag2_r.live <= tag1_r.live;
    end
  end

  // Stage three: the first nonzero chunk gives the common prefix length.
  always_comb begin
    m_nxt = aiptm_pkg::LEN_W'(aiptm_pkg::ADDR_BITS);
    for (int c = aiptm_pkg::CHUNKS - 1; c >= 0; c--) begin
      if (nz2_r[c]) begin
        m_nxt = aiptm_pkg::LEN_W'(c * aiptm_pkg::CHUNK_W) + aiptm_pkg::LEN_W'(lz2_r[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    result_r.qualify   <= tag2_r.qualify;
    result_r.last      <= tag2_r.last;
    result_r.peer      <= tag2_r.peer;
    result_r.match_len <= m_nxt;
    result_r.prefix    <= prefix2_r;
    if (!rst_n) begin
      result_r.live <= 1'b0;
    end else begin
      result_r.live <= tag2_r.live;
    end
  end

  assign result = result_r;

endmodule

[src/aiptm_ctrl.sv]
module aiptm_ctrl (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic [aiptm_pkg::MASK_W-1:0]            peer_enable_mask,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  aiptm_pkg::in_item_t                     in_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output aiptm_pkg::out_item_t                    out_data,
  output logic                                    ram_we,
  output logic [aiptm_pkg::IDX_W-1:0]             ram_waddr,
  output aiptm_pkg::slot_entry_t                  ram_wdata,
  output logic [aiptm_pkg::IDX_W-1:0]             ram_raddr,
  output aiptm_pkg::tag_t                         tag,
  output logic [aiptm_pkg::ADDR_BITS-1:0]         key,
  input  aiptm_pkg::match_t                       match_res
);

  aiptm_pkg::state_t state_r, state_nxt;

  // Current item.
  logic                                    mode_r;
  logic [aiptm_pkg::PEER_W-1:0]            peer_r;
  logic                                    in_range_r;
  logic [aiptm_pkg::ADDR_BITS-1:0]         key_r;
  logic [aiptm_pkg::LEN_W-1:0]             plen_r;

  // Scan counters.
  logic [aiptm_pkg::PEER_W-1:0] peer_cnt_r, peer_cnt_nxt;
  logic [aiptm_pkg::SLOT_W-1:0] slot_cnt_r, slot_cnt_nxt;

  // Running decision.
  logic                               ok_r, ok_nxt;
  logic [aiptm_pkg::FPEER_W-1:0]      found_r, found_nxt;
  logic [aiptm_pkg::LEN_W-1:0]        best_r, best_nxt;
  logic                               exact_r, exact_nxt;
  logic                               dup_r, dup_nxt;

  logic [aiptm_pkg::NSLOTS-1:0] slot_valid_r;
  aiptm_pkg::tag_t              tag_r, tag_nxt;

  logic                          out_valid_r, out_valid_nxt;
  aiptm_pkg::out_item_t          out_data_r, out_data_nxt;

  logic                          accept;
  logic                          load;
  logic                          last_issue;
  logic                          peer_en;
  logic [31:0]                   peer_ext;
  logic [31:0]                   base_idx;
  logic                          free_any;
  logic [aiptm_pkg::SLOT_W-1:0]  free_slot;
  logic                          peer_in_range;

  assign accept        = in_valid && in_ready;
  assign in_ready      = (state_r == aiptm_pkg::ST_IDLE);
  assign peer_in_range = (32'(in_data.peer_number) < aiptm_pkg::PEERS);

  // Read address of the slot under scan.
  assign ram_raddr = aiptm_pkg::IDX_W'(32'(peer_cnt_r) * aiptm_pkg::SLOTS_PER_PEER
                                      + 32'(slot_cnt_r));

  // Lookups consider only peers whose enable bit exists and is set.
  assign peer_ext = 32'(peer_cnt_r);
  assign peer_en  = (peer_ext < aiptm_pkg::MASK_W) && peer_enable_mask[peer_ext[2:0]];

  assign last_issue = (32'(slot_cnt_r) == aiptm_pkg::SLOTS_PER_PEER - 1) &&
                      ((mode_r == aiptm_pkg::MODE_ADD) ||
                       (32'(peer_cnt_r) == aiptm_pkg::PEERS - 1));

  // Lowest free slot of the add peer.
  assign base_idx = 32'(peer_r) * aiptm_pkg::SLOTS_PER_PEER;

  always_comb begin
    free_any  = 1'b0;
    free_slot = '0;
    for (int s = aiptm_pkg::SLOTS_PER_PEER - 1; s >= 0; s--) begin
      if (!slot_valid_r[aiptm_pkg::IDX_W'(base_idx + 32'(s))]) begin
        free_any  = 1'b1;
        free_slot = aiptm_pkg::SLOT_W'(s);
      end
    end
    free_any = free_any && in_range_r;
  end

  // Next state, tag issue, decision update and result build.
  always_comb begin
    state_nxt     = state_r;
    peer_cnt_nxt  = peer_cnt_r;
    slot_cnt_nxt  = slot_cnt_r;
    ok_nxt        = ok_r;
    found_nxt     = found_r;
    best_nxt      = best_r;
    exact_nxt     = exact_r;
    dup_nxt       = dup_r;
    tag_nxt       = '0;
    load          = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;

    case (state_r)
      aiptm_pkg::ST_IDLE: begin
        if (accept) begin
          ok_nxt       = 1'b0;
          found_nxt    = '0;
          best_nxt     = '0;
          exact_nxt    = 1'b0;
          dup_nxt      = 1'b0;
          slot_cnt_nxt = '0;
          if (in_data.mode == aiptm_pkg::MODE_ADD) begin
            peer_cnt_nxt = aiptm_pkg::PEER_W'(in_data.peer_number);
            state_nxt    = peer_in_range ? aiptm_pkg::ST_ISSUE : aiptm_pkg::ST_FIN;
          end else begin
            peer_cnt_nxt = '0;
            state_nxt    = aiptm_pkg::ST_ISSUE;
          end
        end
      end
      aiptm_pkg::ST_ISSUE: begin
        tag_nxt.live    = 1'b1;
        tag_nxt.qualify = slot_valid_r[ram_raddr] &&
                          ((mode_r == aiptm_pkg::MODE_ADD) || peer_en);
        tag_nxt.last    = last_issue;
        tag_nxt.peer    = peer_cnt_r;
        if (last_issue) begin
          state_nxt = aiptm_pkg::ST_DRAIN;
        end else if (32'(slot_cnt_r) == aiptm_pkg::SLOTS_PER_PEER - 1) begin
          slot_cnt_nxt = '0;
          peer_cnt_nxt = peer_cnt_r + 1'b1;
        end else begin
          slot_cnt_nxt = slot_cnt_r + 1'b1;
        end
      end
      aiptm_pkg::ST_DRAIN: begin
        if (match_res.live && match_res.last) begin
          state_nxt = aiptm_pkg::ST_FIN;
        end
      end
      aiptm_pkg::ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          load          = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = aiptm_pkg::ST_IDLE;
          if (mode_r == aiptm_pkg::MODE_ADD) begin
            out_data_nxt.ok         = dup_r || free_any;
            out_data_nxt.found_peer = '0;
            out_data_nxt.match_len  = '0;
            out_data_nxt.exact_hit  = 1'b0;
          end else begin
            out_data_nxt.ok         = ok_r;
            out_data_nxt.found_peer = found_r;
            out_data_nxt.match_len  = best_r;
            out_data_nxt.exact_hit  = exact_r;
          end
        end
      end
      default: begin
        state_nxt = aiptm_pkg::ST_IDLE;
      end
    endcase

    // Each qualifying slot that leaves the match pipeline updates the decision until an exact hit.
    if (match_res.live && match_res.qualify) begin
      if (mode_r == aiptm_pkg::MODE_ADD) begin
        if ((match_res.match_len == aiptm_pkg::LEN_W'(aiptm_pkg::ADDR_BITS)) &&
            (match_res.prefix == plen_r)) begin
          dup_nxt = 1'b1;
        end
      end else if (!exact_r && (match_res.match_len >= match_res.prefix)) begin
        if ((match_res.match_len > best_r) || (best_r == '0)) begin
          ok_nxt    = 1'b1;
          found_nxt = aiptm_pkg::FPEER_W'(32'(match_res.peer));
          best_nxt  = match_res.match_len;
        end
        if (match_res.match_len == aiptm_pkg::LEN_W'(aiptm_pkg::ADDR_BITS)) begin
          exact_nxt = 1'b1;
        end
      end
    end
  end

  // Slot write when an add stores a new prefix.
  assign ram_we    = load && (mode_r == aiptm_pkg::MODE_ADD) && !dup_r && free_any;
  assign ram_waddr = aiptm_pkg::IDX_W'(base_idx + 32'(free_slot));
  assign ram_wdata = '{addr_upper: key_r[aiptm_pkg::ADDR_BITS-1:aiptm_pkg::HALF_W],
                       addr_lower: key_r[aiptm_pkg::HALF_W-1:0],
                       prefix:     plen_r};

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= aiptm_pkg::ST_IDLE;
      slot_valid_r <= '0;
      tag_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tag_r       <= tag_nxt;
      out_valid_r <= out_valid_nxt;
      if (ram_we) begin
        slot_valid_r[ram_waddr] <= 1'b1;
      end
    end
  end

  // Item, counter and decision registers.
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r     <= in_data.mode;
      peer_r     <= aiptm_pkg::PEER_W'(in_data.peer_number);
      in_range_r <= peer_in_range;
      key_r      <= {in_data.addr_high, in_data.addr_low};
      plen_r     <= in_data.prefix_len;
    end
    peer_cnt_r <= peer_cnt_nxt;
    slot_cnt_r <= slot_cnt_nxt;
    ok_r       <= ok_nxt;
    found_r    <= found_nxt;
    best_r     <= best_nxt;
    exact_r    <= exact_nxt;
    dup_r      <= dup_nxt;
    out_data_r <= out_data_nxt;
  end

  assign tag       = tag_r;
  assign key       = key_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[tb/sv/tb_allowed_ip_prefix_match_table.sv]
module tb_allowed_ip_prefix_match_table;

  localparam int CLK_HALF    = 10;
  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 190;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_ready;
  aiptm_pkg::in_item_t  in_data = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  aiptm_pkg::out_item_t out_data;

  logic                             psel = 1'b0;
  logic                             penable = 1'b0;
  logic                             pwrite = 1'b0;
  logic [aiptm_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [aiptm_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [aiptm_pkg::CFG_DATA_W-1:0] prdata;
  logic                             pready;

  // Prefix table as the testbench sees it.
  logic [aiptm_pkg::MASK_W-1:0] en_mask = '0;
  logic                         tbl_valid [aiptm_pkg::NSLOTS];
  logic [aiptm_pkg::HALF_W-1:0] tbl_hi [aiptm_pkg::NSLOTS];
  logic [aiptm_pkg::HALF_W-1:0] tbl_lo [aiptm_pkg::NSLOTS];
  logic [aiptm_pkg::LEN_W-1:0]  tbl_plen [aiptm_pkg::NSLOTS];

  // Items waiting to be driven, answers waiting to arrive, prefixes offered so far.
  aiptm_pkg::in_item_t  item_q [$];
  aiptm_pkg::out_item_t resp_q [$];
  aiptm_pkg::in_item_t  seen_q [$];

  logic                 in_acc = 1'b0;
  logic                 out_acc = 1'b0;
  int                   in_gap = 0;
  int                   out_wait = 0;
  bit                   calm = 1'b0;
  int                   err_count = 0;
  int unsigned          cycle_cnt = 0;
  aiptm_pkg::out_item_t want;

  allowed_ip_prefix_match_table u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Run length guard.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers outstanding", cycle_cnt, resp_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic note_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_cnt, what);
    err_count++;
  endtask

  // Number of leading bits two 128-bit addresses have in common.
  function automatic int shared_bits(logic [127:0] a, logic [127:0] b);
    logic [127:0] d;
    int n;
    d = a ^ b;
    n = 0;
    while (n < aiptm_pkg::ADDR_BITS && !d[127-n]) n++;
    return n;
  endfunction

  // Applies one item to the table and returns the answer the block must give.
  function automatic aiptm_pkg::out_item_t table_response(aiptm_pkg::in_item_t it);
    aiptm_pkg::out_item_t r;
    int base, k, m, best;
    bit done;
    r = '0;
    best = 0;
    done = 1'b0;
    if (it.mode == aiptm_pkg::MODE_ADD) begin
      if (it.peer_number < aiptm_pkg::PEERS) begin
        base = it.peer_number * aiptm_pkg::SLOTS_PER_PEER;
        // An identical prefix already stored counts as success.
        for (int s = 0; s < aiptm_pkg::SLOTS_PER_PEER; s++) begin
          k = base + s;
          if (!r.ok && tbl_valid[k] && tbl_hi[k] == it.addr_high &&
              tbl_lo[k] == it.addr_low && tbl_plen[k] == it.prefix_len) begin
            r.ok = 1'b1;
          end
        end
        // Otherwise take the lowest free slot of that peer.
        for (int s = 0; s < aiptm_pkg::SLOTS_PER_PEER; s++) begin
          k = base + s;
          if (!r.ok && !tbl_valid[k]) begin
            tbl_valid[k] = 1'b1;
            tbl_hi[k]    = it.addr_high;
            tbl_lo[k]    = it.addr_low;
            tbl_plen[k]  = it.prefix_len;
            r.ok         = 1'b1;
          end
        end
      end
    end else begin
      // Scan enabled peers in order; a full-length match stops the scan.
      for (int p = 0; p < aiptm_pkg::PEERS && !done; p++) begin
        if (p < aiptm_pkg::MASK_W && en_mask[p]) begin
          for (int s = 0; s < aiptm_pkg::SLOTS_PER_PEER && !done; s++) begin
            k = p * aiptm_pkg::SLOTS_PER_PEER + s;
            if (tbl_valid[k]) begin
              m = shared_bits({tbl_hi[k], tbl_lo[k]}, {it.addr_high, it.addr_low});
              if (m >= tbl_plen[k] && (m > best || best == 0)) begin
                r.ok         = 1'b1;
                r.found_peer = aiptm_pkg::FPEER_W'(p);
                best         = m;
              end
              if (best == aiptm_pkg::ADDR_BITS) begin
                r.exact_hit = 1'b1;
                done        = 1'b1;
              end
            end
          end
        end
      end
      r.match_len = aiptm_pkg::LEN_W'(best);
    end
    return r;
  endfunction

  // Wait count for one side, with runs of back-to-back traffic.
  function automatic int pick_gap();
    if (calm || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  // Address that shares a random number of leading bits with the given one.
  function automatic logic [127:0] nudge(logic [127:0] a);
    logic [127:0] r;
    int k;
    k = ($urandom_range(0, 7) == 0) ? aiptm_pkg::ADDR_BITS : $urandom_range(0, 127);
    if (k == aiptm_pkg::ADDR_BITS) return a;
    r = {$urandom, $urandom, $urandom, $urandom};
    for (int i = 0; i < k; i++) r[127-i] = a[127-i];
    r[127-k] = ~a[127-k];
    return r;
  endfunction

  task automatic push_item(logic m, logic [2:0] peer, logic [127:0] a,
                           logic [aiptm_pkg::LEN_W-1:0] plen);
    aiptm_pkg::in_item_t it;
    it.mode        = m;
    it.peer_number = peer;
    it.addr_high   = a[127:64];
    it.addr_low    = a[63:0];
    it.prefix_len  = plen;
    item_q.push_back(it);
    if (m == aiptm_pkg::MODE_ADD) seen_q.push_back(it);
  endtask

  // Write the enable mask, then read it back.
  task automatic set_peer_mask(logic [aiptm_pkg::MASK_W-1:0] v);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= aiptm_pkg::CFG_ADDR_W'({aiptm_pkg::REG_PEER_ENABLE, 2'b00});
    pwdata  <= aiptm_pkg::CFG_DATA_W'(v);
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    en_mask = v;
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== aiptm_pkg::CFG_DATA_W'(v)) begin
      note_mismatch($sformatf("mask read back %0h, wrote %0h", prdata, v));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Hold off until every item is in and every answer is out, then let the pipeline settle.
  task automatic wait_idle();
    while (item_q.size() != 0 || in_valid || resp_q.size() != 0) @(posedge clk);
    repeat (aiptm_pkg::NSLOTS + 8) @(posedge clk);
  endtask

  // Item source: presents queued items, with a random gap after each accepted one.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else if (!in_valid || in_acc) begin
      if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (item_q.size() != 0) begin
        in_data  <= item_q.pop_front();
        in_valid <= 1'b1;
        in_gap   <= pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result sink: stalls for a random number of cycles after each accepted item.
  always @(negedge clk) begin : result_sink
    int stall;
    if (out_acc) begin
      stall = pick_gap();
      out_wait  <= stall;
      out_ready <= (stall == 0);
    end else if (out_wait != 0) begin
      out_wait  <= out_wait - 1;
      out_ready <= (out_wait == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Checks each answer against the oldest prediction, then predicts for a newly accepted item.
  always @(posedge clk) begin
    in_acc  <= rst_n && in_valid && in_ready;
    out_acc <= rst_n && out_valid && out_ready;
    if (rst_n && out_valid && out_ready) begin
      if (resp_q.size() == 0) begin
        note_mismatch("answer arrived with nothing outstanding");
      end else begin
        want = resp_q.pop_front();
        if (out_data.ok !== want.ok)
          note_mismatch($sformatf("ok got %0d want %0d", out_data.ok, want.ok));
        if (out_data.found_peer !== want.found_peer)
          note_mismatch($sformatf("found_peer got %0d want %0d",
                                  out_data.found_peer, want.found_peer));
        if (out_data.match_len !== want.match_len)
          note_mismatch($sformatf("match_len got %0d want %0d",
                                  out_data.match_len, want.match_len));
        if (out_data.exact_hit !== want.exact_hit)
          note_mismatch($sformatf("exact_hit got %0d want %0d",
                                  out_data.exact_hit, want.exact_hit));
      end
    end
    if (rst_n && in_valid && in_ready) begin
      resp_q.push_back(table_response(in_data));
    end
  end

  initial begin : stimulus
    logic [aiptm_pkg::MASK_W-1:0] masks [PHASES];
    logic [127:0]                 a;
    logic [aiptm_pkg::LEN_W-1:0]  plen;
    aiptm_pkg::in_item_t          pick;
    int                           roll;

    masks = '{8'hFF, 8'h00, 8'h01, 8'h80, 8'hA5, 8'h5A, 8'h00, 8'h00};
    masks[6] = aiptm_pkg::MASK_W'($urandom);
    masks[7] = aiptm_pkg::MASK_W'($urandom);
    for (int i = 0; i < aiptm_pkg::NSLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_hi[i]    = '0;
      tbl_lo[i]    = '0;
      tbl_plen[i]  = '0;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, all peers enabled.
    set_peer_mask(8'hFF);
    @(posedge clk);
    // Lookup in an empty table finds nothing.
    push_item(aiptm_pkg::MODE_LOOKUP, 3'd0, '0, 8'd0);
    // Full-length prefix, the same again, then the same address with another length.
    push_item(aiptm_pkg::MODE_ADD, 3'd0, '1, 8'd128);
    push_item(aiptm_pkg::MODE_ADD, 3'd0, '1, 8'd128);
    push_item(aiptm_pkg::MODE_ADD, 3'd0, '1, 8'd127);
    push_item(aiptm_pkg::MODE_LOOKUP, 3'd7, '1, 8'd255);
    // Zero-length prefixes on two peers: any entry wins while the best match is zero.
    push_item(aiptm_pkg::MODE_ADD, 3'd7, '0, 8'd0);
    push_item(aiptm_pkg::MODE_LOOKUP, 3'd0, '0, 8'd0);
    push_item(aiptm_pkg::MODE_ADD, 3'd5,
              {64'h7FFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF}, 8'd0);
    push_item(aiptm_pkg::MODE_LOOKUP, 3'd0, {64'h8000_0000_0000_0000, 64'h0}, 8'd0);
    // Prefixes longer than an address never match.
    push_item(aiptm_pkg::MODE_ADD, 3'd2, {64'hFFFF_0000_FFFF_0000, 64'h0}, 8'd255);
    push_item(aiptm_pkg::MODE_ADD, 3'd1, {64'hFFFF_0000_FFFF_0000, 64'h0}, 8'd129);
    push_item(aiptm_pkg::MODE_LOOKUP, 3'd0, {64'hFFFF_0000_FFFF_0000, 64'h0}, 8'd0);
    // Filling one peer; the fifth distinct prefix is refused.
    for (int i = 0; i < aiptm_pkg::SLOTS_PER_PEER + 1; i++) begin
      push_item(aiptm_pkg::MODE_ADD, 3'd3, {64'h2001_0DB8_0000_0003, 64'(i)}, 8'd100);
    end
    push_item(aiptm_pkg::MODE_LOOKUP, 3'd0, {64'h2001_0DB8_0000_0003, 64'h1}, 8'd0);
    // A match in the low half; bits past the prefix are stored and compared as given.
    push_item(aiptm_pkg::MODE_ADD, 3'd6, '1, 8'd64);
    push_item(aiptm_pkg::MODE_LOOKUP, 3'd0,
              {64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF}, 8'd0);
    push_item(aiptm_pkg::MODE_ADD, 3'd4, {64'h2001_0DB8_0000_0003, 64'h3}, 8'd64);
    push_item(aiptm_pkg::MODE_LOOKUP, 3'd0, {64'h2001_0DB8_0000_0003, 64'hFFFF}, 8'd0);
    wait_idle();

    // Random phases, each under its own enable mask.
    for (int ph = 0; ph < PHASES; ph++) begin
      calm = (ph == 3);
      set_peer_mask(masks[ph]);
      @(posedge clk);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        plen = ($urandom_range(0, 9) == 0) ? aiptm_pkg::LEN_W'($urandom_range(129, 255))
                                           : aiptm_pkg::LEN_W'($urandom_range(0, 128));
        if (seen_q.size() != 0) begin
          pick = seen_q[$urandom_range(0, seen_q.size() - 1)];
        end
        if (roll < 8 && seen_q.size() != 0) begin
          // Offer a known prefix again, now and then to another peer.
          if (roll < 2) pick.peer_number = 3'($urandom);
          push_item(aiptm_pkg::MODE_ADD, pick.peer_number, {pick.addr_high, pick.addr_low},
                    pick.prefix_len);
        end else if (roll < 30) begin
          if (roll < 12 || seen_q.size() == 0) a = {$urandom, $urandom, $urandom, $urandom};
          else a = nudge({pick.addr_high, pick.addr_low});
          push_item(aiptm_pkg::MODE_ADD, 3'($urandom), a, plen);
        end else begin
          // Lookups mostly land near stored prefixes.
          if (roll < 36 || seen_q.size() == 0) a = {$urandom, $urandom, $urandom, $urandom};
          else a = nudge({pick.addr_high, pick.addr_low});
          push_item(aiptm_pkg::MODE_LOOKUP, 3'($urandom), a, aiptm_pkg::LEN_W'($urandom));
        end
      end
      wait_idle();
    end

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
